// ===== src/adll_pkg.sv =====
// shared constants, types and helpers of the array doubly linked list
package adll_pkg;

    // store geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int LINK_W     = $clog2(DEPTH + 1);

    // port field widths
    localparam int OP_W    = 3;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;
    localparam int CMP_W   = ((LINK_W > POS_W) ? LINK_W : POS_W) + 1;

    // packed stream widths
    localparam int S_TDATA_W = ((OP_W + POS_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

    typedef logic [LINK_W-1:0]     link_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [DATA_WIDTH-1:0] data_t;

    // link code for "no node"
    localparam link_t NIL = LINK_W'(DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_POS  = 3'd1,
        OP_INS_TAIL = 3'd2,
        OP_DEL_HEAD = 3'd3,
        OP_DEL_POS  = 3'd4,
        OP_DEL_TAIL = 3'd5,
        OP_WALK_FWD = 3'd6,
        OP_WALK_REV = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_FREE,
        S_INS_TAIL,
        S_INS_SPLICE,
        S_SEEK,
        S_DEL_HEAD,
        S_DEL_TAIL,
        S_RELEASE,
        S_WALK,
        S_EMIT
    } state_t;

    // node memory access: one read address for all fields, one write per field
    typedef struct packed {
        logic  re;
        addr_t raddr;
        logic  fwd_we;
        addr_t fwd_waddr;
        link_t fwd_wdata;
        logic  bwd_we;
        addr_t bwd_waddr;
        link_t bwd_wdata;
        logic  val_we;
        addr_t val_waddr;
        data_t val_wdata;
    } node_req_t;

    typedef struct packed {
        link_t fwd;
        link_t bwd;
        data_t value;
    } node_rsp_t;

    typedef struct packed {
        status_t            status;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic               last;
    } result_t;

    // sign extend a stored value to the result width
    function automatic logic [VALUE_W-1:0] value_to_out(data_t v);
        logic signed [DATA_WIDTH-1:0] sv;
        sv = v;
        value_to_out = VALUE_W'(sv);
    endfunction

endpackage

// ===== src/adll_ram.sv =====
// generic single write, single read ram with registered read data
module adll_ram #(
    parameter int WIDTH   = 8,
    parameter int DEPTH_N = 16
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH_N)-1:0] waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH_N)-1:0] raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH_N];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/adll_node_mem.sv =====
// node store: value, forward link and backward link memories
module adll_node_mem
    import adll_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  node_req_t req,
    output node_rsp_t rsp
);

    link_t      fwd_q;
    link_t      bwd_q;
    data_t      val_q;
    logic [DEPTH-1:0] fwd_vld_reg;
    logic [DEPTH-1:0] bwd_vld_reg;
    logic       fwd_rvld_reg;
    logic       bwd_rvld_reg;
    addr_t      raddr_reg;

    adll_ram #(.WIDTH(DATA_WIDTH), .DEPTH_N(DEPTH)) u_val_ram (
        .aclk  (aclk),
        .we    (req.val_we),
        .waddr (req.val_waddr),
        .wdata (req.val_wdata),
        .re    (req.re),
        .raddr (req.raddr),
        .rdata (val_q)
    );

    adll_ram #(.WIDTH(LINK_W), .DEPTH_N(DEPTH)) u_fwd_ram (
        .aclk  (aclk),
        .we    (req.fwd_we),
        .waddr (req.fwd_waddr),
        .wdata (req.fwd_wdata),
        .re    (req.re),
        .raddr (req.raddr),
        .rdata (fwd_q)
    );

    adll_ram #(.WIDTH(LINK_W), .DEPTH_N(DEPTH)) u_bwd_ram (
        .aclk  (aclk),
        .we    (req.bwd_we),
        .waddr (req.bwd_waddr),
        .wdata (req.bwd_wdata),
        .re    (req.re),
        .raddr (req.raddr),
        .rdata (bwd_q)
    );

    // written flags for the link memories, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_vld_reg <= '0;
            bwd_vld_reg <= '0;
        end else begin
            if (req.fwd_we) begin
                fwd_vld_reg[req.fwd_waddr] <= 1'b1;
            end
            if (req.bwd_we) begin
                bwd_vld_reg[req.bwd_waddr] <= 1'b1;
            end
        end
    end

    // flags and address travel with the read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_rvld_reg <= 1'b0;
            bwd_rvld_reg <= 1'b0;
            raddr_reg    <= '0;
        end else if (req.re) begin
            fwd_rvld_reg <= fwd_vld_reg[req.raddr];
            bwd_rvld_reg <= bwd_vld_reg[req.raddr];
            raddr_reg    <= req.raddr;
        end
    end

    // unwritten links read as their reset chain
    always_comb begin
        rsp.value = val_q;
        rsp.fwd   = fwd_rvld_reg ? fwd_q : (LINK_W'(raddr_reg) + LINK_W'(1));
        rsp.bwd   = bwd_rvld_reg ? bwd_q : NIL;
    end

endmodule

// ===== src/adll_ctrl.sv =====
// request sequencer: list pointers, free list and node read-modify-write steps
module adll_ctrl
    import adll_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  op_t              in_op,
    input  logic [POS_W-1:0] in_pos,
    input  logic [VALUE_W-1:0] in_value,
    input  logic             out_ready,
    output logic             res_valid,
    output result_t          res,
    output node_req_t        mem_req,
    input  node_rsp_t        mem_rsp
);

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    data_t              val_reg, val_next;
    link_t              head_reg, head_next;
    link_t              tail_reg, tail_next;
    link_t              free_reg, free_next;
    link_t              count_reg, count_next;
    link_t              cur_reg, cur_next;
    link_t              node_reg, node_next;
    link_t              prev_reg, prev_next;
    logic [POS_W-1:0]   rem_reg, rem_next;
    status_t            rstat_reg, rstat_next;
    logic [VALUE_W-1:0] rval_reg, rval_next;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             is_ins;
    logic             ins_head;
    logic             ins_tail;
    logic             del_head;
    logic             del_tail;
    link_t            walk_next;

    // position tests against the element count
    always_comb begin
        pos_ext   = CMP_W'(pos_reg);
        cnt_ext   = CMP_W'(count_reg);
        is_ins    = op_reg inside {OP_INS_HEAD, OP_INS_POS, OP_INS_TAIL};
        ins_head  = (op_reg == OP_INS_HEAD) || ((op_reg == OP_INS_POS) && (pos_ext == 1));
        ins_tail  = (op_reg == OP_INS_TAIL) ||
                    ((op_reg == OP_INS_POS) && (pos_ext == cnt_ext + CMP_W'(1)));
        del_head  = (op_reg == OP_DEL_HEAD) || ((op_reg == OP_DEL_POS) && (pos_ext == 1));
        del_tail  = (op_reg == OP_DEL_TAIL) || ((op_reg == OP_DEL_POS) && (pos_ext == cnt_ext));
        walk_next = (op_reg == OP_WALK_FWD) ? mem_rsp.fwd : mem_rsp.bwd;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= NIL;
            tail_reg  <= NIL;
            free_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            free_reg  <= free_next;
            count_reg <= count_next;
        end
    end

    // request and working registers
    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        cur_reg   <= cur_next;
        node_reg  <= node_next;
        prev_reg  <= prev_next;
        rem_reg   <= rem_next;
        rstat_reg <= rstat_next;
        rval_reg  <= rval_next;
    end

    // next state, memory accesses and results
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        free_next  = free_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        node_next  = node_reg;
        prev_next  = prev_reg;
        rem_next   = rem_reg;
        rstat_next = rstat_reg;
        rval_next  = rval_reg;

        in_ready   = 1'b0;
        res_valid  = 1'b0;
        res.status = rstat_reg;
        res.value  = rval_reg;
        res.count  = COUNT_W'(count_reg);
        res.last   = 1'b1;
        mem_req    = '0;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next    = in_op;
                    pos_next   = in_pos;
                    val_next   = DATA_WIDTH'(in_value);
                    state_next = S_DECODE;
                end
            end

            S_DECODE: begin
                rstat_next = ST_OK;
                rval_next  = '0;
                case (op_reg)
                    OP_INS_HEAD, OP_INS_POS, OP_INS_TAIL: begin
                        if (free_reg == NIL) begin
                            rstat_next = ST_FULL;
                            state_next = S_EMIT;
                        end else if ((op_reg == OP_INS_POS) &&
                                     ((pos_ext == 0) || (pos_ext > cnt_ext + CMP_W'(1)))) begin
                            rstat_next = ST_BADPOS;
                            state_next = S_EMIT;
                        end else begin
                            node_next     = free_reg;
                            mem_req.re    = 1'b1;
                            mem_req.raddr = free_reg[ADDR_W-1:0];
                            state_next    = S_INS_FREE;
                        end
                    end
                    OP_DEL_HEAD, OP_DEL_POS, OP_DEL_TAIL: begin
                        if ((head_reg == NIL) || (count_reg == 0)) begin
                            rstat_next = ST_EMPTY;
                            state_next = S_EMIT;
                        end else if ((op_reg == OP_DEL_POS) &&
                                     ((pos_ext == 0) || (pos_ext > cnt_ext))) begin
                            rstat_next = ST_BADPOS;
                            state_next = S_EMIT;
                        end else if (del_head) begin
                            node_next     = head_reg;
                            mem_req.re    = 1'b1;
                            mem_req.raddr = head_reg[ADDR_W-1:0];
                            state_next    = S_DEL_HEAD;
                        end else if (del_tail) begin
                            node_next     = tail_reg;
                            mem_req.re    = 1'b1;
                            mem_req.raddr = tail_reg[ADDR_W-1:0];
                            state_next    = S_DEL_TAIL;
                        end else begin
                            cur_next      = head_reg;
                            rem_next      = pos_reg - POS_W'(1);
                            mem_req.re    = 1'b1;
                            mem_req.raddr = head_reg[ADDR_W-1:0];
                            state_next    = S_SEEK;
                        end
                    end
                    OP_WALK_FWD, OP_WALK_REV: begin
                        cur_next = (op_reg == OP_WALK_FWD) ? head_reg : tail_reg;
                        if (cur_next == NIL) begin
                            rstat_next = ST_EMPTY;
                            state_next = S_EMIT;
                        end else begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = cur_next[ADDR_W-1:0];
                            state_next    = S_WALK;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            // take the free node and link it where the request asks
            S_INS_FREE: begin
                free_next         = mem_rsp.fwd;
                count_next        = count_reg + LINK_W'(1);
                mem_req.val_we    = 1'b1;
                mem_req.val_waddr = node_reg[ADDR_W-1:0];
                mem_req.val_wdata = val_reg;
                if (ins_head) begin
                    mem_req.fwd_we    = 1'b1;
                    mem_req.fwd_waddr = node_reg[ADDR_W-1:0];
                    mem_req.fwd_wdata = head_reg;
                    if (head_reg != NIL) begin
                        mem_req.bwd_we    = 1'b1;
                        mem_req.bwd_waddr = head_reg[ADDR_W-1:0];
                        mem_req.bwd_wdata = node_reg;
                    end
                    if (tail_reg == NIL) begin
                        tail_next = node_reg;
                    end
                    head_next  = node_reg;
                    state_next = S_EMIT;
                end else if (ins_tail) begin
                    mem_req.fwd_we    = 1'b1;
                    mem_req.fwd_waddr = node_reg[ADDR_W-1:0];
                    mem_req.fwd_wdata = NIL;
                    mem_req.bwd_we    = 1'b1;
                    mem_req.bwd_waddr = node_reg[ADDR_W-1:0];
                    mem_req.bwd_wdata = tail_reg;
                    prev_next         = tail_reg;
                    tail_next         = node_reg;
                    if (tail_reg == NIL) begin
                        head_next  = node_reg;
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_INS_TAIL;
                    end
                end else begin
                    cur_next      = head_reg;
                    rem_next      = pos_reg - POS_W'(1);
                    mem_req.re    = 1'b1;
                    mem_req.raddr = head_reg[ADDR_W-1:0];
                    state_next    = S_SEEK;
                end
            end

            // old tail points at the new node
            S_INS_TAIL: begin
                mem_req.fwd_we    = 1'b1;
                mem_req.fwd_waddr = prev_reg[ADDR_W-1:0];
                mem_req.fwd_wdata = node_reg;
                state_next        = S_EMIT;
            end

            // follow forward links one node per cycle
            S_SEEK: begin
                if (rem_reg != 0) begin
                    cur_next      = mem_rsp.fwd;
                    rem_next      = rem_reg - POS_W'(1);
                    mem_req.re    = 1'b1;
                    mem_req.raddr = mem_rsp.fwd[ADDR_W-1:0];
                end else if (is_ins) begin
                    mem_req.fwd_we    = 1'b1;
                    mem_req.fwd_waddr = node_reg[ADDR_W-1:0];
                    mem_req.fwd_wdata = cur_reg;
                    mem_req.bwd_we    = 1'b1;
                    mem_req.bwd_waddr = node_reg[ADDR_W-1:0];
                    mem_req.bwd_wdata = mem_rsp.bwd;
                    prev_next         = mem_rsp.bwd;
                    state_next        = S_INS_SPLICE;
                end else begin
                    node_next         = cur_reg;
                    rval_next         = value_to_out(mem_rsp.value);
                    mem_req.fwd_we    = 1'b1;
                    mem_req.fwd_waddr = mem_rsp.bwd[ADDR_W-1:0];
                    mem_req.fwd_wdata = mem_rsp.fwd;
                    mem_req.bwd_we    = 1'b1;
                    mem_req.bwd_waddr = mem_rsp.fwd[ADDR_W-1:0];
                    mem_req.bwd_wdata = mem_rsp.bwd;
                    state_next        = S_RELEASE;
                end
            end

            // neighbors point at the new node
            S_INS_SPLICE: begin
                mem_req.fwd_we    = 1'b1;
                mem_req.fwd_waddr = prev_reg[ADDR_W-1:0];
                mem_req.fwd_wdata = node_reg;
                mem_req.bwd_we    = 1'b1;
                mem_req.bwd_waddr = cur_reg[ADDR_W-1:0];
                mem_req.bwd_wdata = node_reg;
                state_next        = S_EMIT;
            end

            S_DEL_HEAD: begin
                rval_next = value_to_out(mem_rsp.value);
                head_next = mem_rsp.fwd;
                if (mem_rsp.fwd == NIL) begin
                    tail_next = NIL;
                end else begin
                    mem_req.bwd_we    = 1'b1;
                    mem_req.bwd_waddr = mem_rsp.fwd[ADDR_W-1:0];
                    mem_req.bwd_wdata = NIL;
                end
                state_next = S_RELEASE;
            end

            S_DEL_TAIL: begin
                rval_next = value_to_out(mem_rsp.value);
                tail_next = mem_rsp.bwd;
                if (mem_rsp.bwd == NIL) begin
                    head_next = NIL;
                end else begin
                    mem_req.fwd_we    = 1'b1;
                    mem_req.fwd_waddr = mem_rsp.bwd[ADDR_W-1:0];
                    mem_req.fwd_wdata = NIL;
                end
                state_next = S_RELEASE;
            end

            // removed node goes to the front of the free list
            S_RELEASE: begin
                mem_req.fwd_we    = 1'b1;
                mem_req.fwd_waddr = node_reg[ADDR_W-1:0];
                mem_req.fwd_wdata = free_reg;
                mem_req.bwd_we    = 1'b1;
                mem_req.bwd_waddr = node_reg[ADDR_W-1:0];
                mem_req.bwd_wdata = NIL;
                free_next         = node_reg;
                count_next        = count_reg - LINK_W'(1);
                state_next        = S_EMIT;
            end

            // one item per node, next read issued as the item leaves
            S_WALK: begin
                res_valid  = 1'b1;
                res.status = ST_OK;
                res.value  = value_to_out(mem_rsp.value);
                res.last   = (walk_next == NIL);
                if (out_ready) begin
                    if (walk_next == NIL) begin
                        state_next = S_IDLE;
                    end else begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = walk_next[ADDR_W-1:0];
                    end
                end
            end

            S_EMIT: begin
                res_valid = 1'b1;
                if (out_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/array_doubly_linked_list_top.sv =====
// Doubly linked list of up to 16 values in node memories with a free list.
// One request is worked at a time. Positional requests pass one node per
// cycle on the way to the position, since the forward link memory is read
// once per cycle while walking to the position. During a walk, the link
// read of the next node overlaps the item being sent. Every result leaves
// through an output register, so a result may wait on m_axis_tready while
// the next request is being worked. No clearing pass is needed after reset.
module array_doubly_linked_list_top
    import adll_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // operation [2:0], position [7:3], value_in [39:8]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // value_out [31:0], element_count [36:32], zero fill [39:37]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // status [1:0]
    output logic [1:0]           m_axis_tuser,
    output logic                 m_axis_tlast
);

    node_req_t mem_req;
    node_rsp_t mem_rsp;
    logic      res_valid;
    result_t   res;
    logic      out_ready;
    logic      m_valid_reg;
    result_t   m_res_reg;

    adll_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (op_t'(s_axis_tdata[OP_W-1:0])),
        .in_pos    (s_axis_tdata[OP_W+POS_W-1:OP_W]),
        .in_value  (s_axis_tdata[OP_W+POS_W+VALUE_W-1:OP_W+POS_W]),
        .out_ready (out_ready),
        .res_valid (res_valid),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rsp   (mem_rsp)
    );

    adll_node_mem u_node_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rsp     (mem_rsp)
    );

    // output register
    assign out_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    // pack the result item
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({m_res_reg.count, m_res_reg.value});
    assign m_axis_tuser  = m_res_reg.status;
    assign m_axis_tlast  = m_res_reg.last;

endmodule

// ===== tb/array_doubly_linked_list_top_tb.sv =====
// testbench of the array doubly linked list: directed and random requests checked against a list model
`timescale 1ns / 100ps

module array_doubly_linked_list_top_tb;
    import adll_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // operation [2:0], position [7:3], value_in [39:8]
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // value_out [31:0], element_count [36:32], zero fill [39:37]
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // status [1:0]
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    // list contents in order from head to tail
    logic [VALUE_W-1:0] list_model[$];
    result_t            expected_results[$];

    int errors = 0;
    int stall_cycles = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    bit growing = 1'b1;

    array_doubly_linked_list_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver stalls
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.status = status_t'(m_axis_tuser);
            got.value  = m_axis_tdata[VALUE_W-1:0];
            got.count  = m_axis_tdata[VALUE_W +: COUNT_W];
            got.last   = m_axis_tlast;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected item, status %0d value %h count %0d last %0b",
                         $time, got.status, got.value, got.count, got.last);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    errors++;
                end
                if (got.value !== want.value) begin
                    $display("%0t: value expected %h actual %h", $time, want.value, got.value);
                    errors++;
                end
                if (got.count !== want.count) begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.count, got.count);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
                    errors++;
                end
            end
        end
    end

    // queue one expected result, count taken after the list change
    function automatic void expect_result(status_t status, logic [VALUE_W-1:0] value,
                                          logic last);
        result_t r;
        r.status = status;
        r.value  = value;
        r.count  = COUNT_W'(list_model.size());
        r.last   = last;
        expected_results.push_back(r);
    endfunction

    // apply one request to the list model and queue what it yields
    function automatic void predict_list_request(op_t op, logic [POS_W-1:0] pos,
                                                 logic [VALUE_W-1:0] value);
        int                 cnt;
        int                 idx;
        logic [VALUE_W-1:0] removed;
        cnt = list_model.size();
        case (op)
            OP_INS_HEAD, OP_INS_POS, OP_INS_TAIL: begin
                // full is checked ahead of the position
                if (cnt == DEPTH) begin
                    expect_result(ST_FULL, '0, 1'b1);
                end else if (op == OP_INS_POS && (pos < 1 || pos > cnt + 1)) begin
                    expect_result(ST_BADPOS, '0, 1'b1);
                end else begin
                    idx = (op == OP_INS_HEAD) ? 0 : (op == OP_INS_TAIL) ? cnt : pos - 1;
                    if (idx == cnt) begin
                        list_model.push_back(value);
                    end else begin
                        list_model.insert(idx, value);
                    end
                    expect_result(ST_OK, '0, 1'b1);
                end
            end
            OP_DEL_HEAD, OP_DEL_POS, OP_DEL_TAIL: begin
                // empty is checked ahead of the position
                if (cnt == 0) begin
                    expect_result(ST_EMPTY, '0, 1'b1);
                end else if (op == OP_DEL_POS && (pos < 1 || pos > cnt)) begin
                    expect_result(ST_BADPOS, '0, 1'b1);
                end else begin
                    idx = (op == OP_DEL_HEAD) ? 0 : (op == OP_DEL_TAIL) ? cnt - 1 : pos - 1;
                    removed = list_model[idx];
                    list_model.delete(idx);
                    expect_result(ST_OK, removed, 1'b1);
                end
            end
            default: begin
                // walks: one item per element, a single empty item if none
                if (cnt == 0) begin
                    expect_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < cnt; i++) begin
                        idx = (op == OP_WALK_FWD) ? i : cnt - 1 - i;
                        expect_result(ST_OK, list_model[idx], i == cnt - 1);
                    end
                end
            end
        endcase
    endfunction

    // present one request and wait until it is taken
    task automatic send_request(op_t op, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] value);
        if ($urandom_range(99) < sender_idle_pct) begin
            @(negedge aclk) s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(20)) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, pos, op};
        do @(posedge aclk); while (!s_axis_tready);
        predict_list_request(op, pos, value);
    endtask

    // random value with a bias to the extremes
    function automatic logic [VALUE_W-1:0] random_value();
        logic [1:0] pick;
        if ($urandom_range(7) != 0) begin
            return $urandom;
        end
        pick = $urandom_range(3);
        case (pick)
            2'd0: return 32'h0000_0000;
            2'd1: return 32'h8000_0000;
            2'd2: return 32'h7fff_ffff;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    task automatic set_idling(int sender_pct, int receiver_pct);
        sender_idle_pct   = sender_pct;
        receiver_idle_pct = receiver_pct;
    endtask

    // every walk and delete request, and inserts at bad positions, against an empty list
    task automatic test_empty_list();
        send_request(OP_WALK_FWD, 5'd0, 32'h0);
        send_request(OP_WALK_REV, 5'd31, 32'hffff_ffff);
        send_request(OP_DEL_HEAD, 5'd1, 32'h0);
        send_request(OP_DEL_POS, 5'd0, 32'h0);
        send_request(OP_DEL_TAIL, 5'd3, 32'h0);
        send_request(OP_INS_POS, 5'd0, 32'h1234_5678);
        send_request(OP_INS_POS, 5'd2, 32'h1234_5678);
    endtask

    // inserts at every place plus an out of range position
    task automatic test_inserts();
        send_request(OP_INS_POS, 5'd1, 32'h8000_0000);
        send_request(OP_INS_HEAD, 5'd0, 32'h7fff_ffff);
        send_request(OP_INS_TAIL, 5'd0, 32'hffff_ffff);
        send_request(OP_INS_POS, 5'd2, 32'h0000_0000);
        send_request(OP_INS_POS, 5'd5, 32'h0000_0001);
        send_request(OP_INS_POS, 5'd31, 32'ha5a5_a5a5);
    endtask

    task automatic test_walks();
        send_request(OP_WALK_FWD, 5'd0, 32'h0);
        send_request(OP_WALK_REV, 5'd0, 32'h0);
    endtask

    // deletes from the middle, the ends, and just past the end
    task automatic test_deletes();
        send_request(OP_DEL_POS, 5'd3, 32'h0);
        send_request(OP_DEL_POS, 5'd5, 32'h0);
        send_request(OP_DEL_POS, 5'd4, 32'h0);
        send_request(OP_DEL_POS, 5'd1, 32'h0);
        send_request(OP_DEL_HEAD, 5'd0, 32'h0);
        send_request(OP_DEL_TAIL, 5'd0, 32'h0);
    endtask

    // fill the store, push against it, walk it full, then drain it
    task automatic test_full_store();
        int kind;
        while (list_model.size() < DEPTH) begin
            send_request(OP_INS_TAIL, POS_W'($urandom), random_value());
        end
        send_request(OP_INS_HEAD, POS_W'($urandom), random_value());
        send_request(OP_INS_POS, 5'd0, random_value());
        send_request(OP_INS_TAIL, 5'd31, random_value());
        send_request(OP_WALK_FWD, POS_W'($urandom), random_value());
        send_request(OP_WALK_REV, POS_W'($urandom), random_value());
        while (list_model.size() > 0) begin
            kind = $urandom_range(3);
            if (kind == 0) begin
                send_request(OP_DEL_HEAD, POS_W'($urandom), random_value());
            end else if (kind == 1) begin
                send_request(OP_DEL_TAIL, POS_W'($urandom), random_value());
            end else begin
                send_request(OP_DEL_POS, POS_W'($urandom_range(1, list_model.size())),
                             random_value());
            end
        end
    endtask

    // mostly valid inserts and deletes that drift the length up and down
    task automatic test_random_mix(int items);
        int   r;
        int   cnt;
        op_t  op;
        logic [POS_W-1:0] pos;
        for (int n = 0; n < items; n++) begin
            cnt = list_model.size();
            if ($urandom_range(15) == 0) begin
                growing = !growing;
            end
            r = $urandom_range(99);
            pos = POS_W'($urandom);
            if (r < 8) begin
                op = $urandom_range(1) ? OP_WALK_FWD : OP_WALK_REV;
            end else if (r < 14) begin
                // noise: any operation at any position
                op = op_t'($urandom_range(7));
            end else if ($urandom_range(99) < (growing ? 70 : 30)) begin
                op = op_t'($urandom_range(2));
                if (op == OP_INS_POS) begin
                    pos = POS_W'($urandom_range(1, cnt + 1));
                end
            end else begin
                op = op_t'(OP_DEL_HEAD + $urandom_range(2));
                if (op == OP_DEL_POS && cnt > 0) begin
                    pos = POS_W'($urandom_range(1, cnt));
                end
            end
            send_request(op, pos, random_value());
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // sender idles rarely, receiver often
        set_idling(13, 70);
        test_empty_list();
        test_inserts();
        test_walks();
        test_deletes();
        test_full_store();
        test_random_mix(80);

        // sender idles often, receiver rarely
        set_idling(70, 13);
        test_full_store();
        test_random_mix(80);

        // back to back on both sides
        set_idling(0, 0);
        test_random_mix(80);

        @(negedge aclk) s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
